[rtl/lfu_cache_policy_core_assert.svh]
`ifndef LFU_CACHE_POLICY_CORE_ASSERT_SVH
`define LFU_CACHE_POLICY_CORE_ASSERT_SVH
// ============================================================================
// LFU cache assertion macros
// Shorthand for concurrent assertions clocked on aclk. The first form is
// masked while aresetn is low, the second also checks during reset.
// ============================================================================

`define LCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define LCP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/lcp_pkg.sv]
// ============================================================================
// LFU cache package
// Sizes, entry layout, controller states and shared control structures.
// ============================================================================
package lcp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;

    localparam int KEY_BITS  = 32;
    localparam int VAL_BITS  = 32;
    localparam int CAP_BITS  = 5;
    localparam int IDX_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_BITS = IDX_BITS;
    localparam int OCC_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    localparam int S_TDATA_BITS = ((KEY_BITS + VAL_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = ((VAL_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 1;

    localparam logic [CAP_BITS-1:0]   CAP_RESET  = CAP_BITS'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_INIT = COUNT_BITS'(1);
    localparam logic [VAL_BITS-1:0]   MISS_VALUE = '1;
    localparam logic [VAL_BITS-1:0]   PUT_VALUE  = '0;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VAL_BITS-1:0]   value;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_BITS-1:0]  rank;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPD_END,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_EVICT,
        OP_FILL
    } op_t;

    typedef struct packed {
        logic                  found;
        logic [IDX_BITS-1:0]   match_idx;
        logic [RANK_BITS-1:0]  match_rank;
        logic [VAL_BITS-1:0]   match_value;
        logic                  vic_found;
        logic [IDX_BITS-1:0]   vic_idx;
        logic [COUNT_BITS-1:0] vic_count;
        logic [RANK_BITS-1:0]  vic_rank;
        logic                  free_found;
        logic [IDX_BITS-1:0]   free_idx;
    } scan_res_t;

    typedef struct packed {
        op_t                  op;
        logic [IDX_BITS-1:0]  tgt_idx;
        logic [RANK_BITS-1:0] ref_rank;
        logic                 is_put;
        logic [KEY_BITS-1:0]  key;
        logic [VAL_BITS-1:0]  value;
    } upd_ctl_t;

endpackage

[rtl/lcp_ram.sv]
// ============================================================================
// LFU cache entry RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module lcp_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/lcp_scan.sv]
// ============================================================================
// LFU cache table scan
// Folds one entry per beat into the key match, the eviction victim (lowest
// count, oldest on a tie) and the lowest free slot.
// ============================================================================
module lcp_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          beat,
    input  logic [lcp_pkg::IDX_BITS-1:0]  beat_idx,
    input  logic                          beat_vld,
    input  lcp_pkg::entry_t               rd_entry,
    input  logic [lcp_pkg::KEY_BITS-1:0]  key,
    output lcp_pkg::scan_res_t            res
);

    import lcp_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      older_tie;

    assign older_tie = (rd_entry.count == res_reg.vic_count) &&
                       (rd_entry.rank > res_reg.vic_rank);

    always_comb begin
        res_next = res_reg;
        if (start) begin
            res_next.found      = 1'b0;
            res_next.vic_found  = 1'b0;
            res_next.free_found = 1'b0;
        end else if (beat) begin
            if (beat_vld && !res_reg.found && (rd_entry.key == key)) begin
                res_next.found       = 1'b1;
                res_next.match_idx   = beat_idx;
                res_next.match_rank  = rd_entry.rank;
                res_next.match_value = rd_entry.value;
            end
            if (beat_vld && (!res_reg.vic_found || (rd_entry.count < res_reg.vic_count) ||
                             older_tie)) begin
                res_next.vic_found = 1'b1;
                res_next.vic_idx   = beat_idx;
                res_next.vic_count = rd_entry.count;
                res_next.vic_rank  = rd_entry.rank;
            end
            if (!beat_vld && !res_reg.free_found) begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = beat_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/lcp_entry_upd.sv]
// ============================================================================
// LFU cache entry rewrite
// Computes the write-back of one entry during the update pass: touch,
// replacement of the victim, or fill of a free slot, with the recency ranks
// of the valid entries more recent than the target (all on a fill) shifted.
// ============================================================================
module lcp_entry_upd (
    input  lcp_pkg::upd_ctl_t             ctl,
    input  logic [lcp_pkg::IDX_BITS-1:0]  beat_idx,
    input  logic                          beat_vld,
    input  lcp_pkg::entry_t               rd_entry,
    output logic                          wr_en,
    output lcp_pkg::entry_t               wr_entry
);

    import lcp_pkg::*;

    logic is_tgt;

    assign is_tgt = (beat_idx == ctl.tgt_idx);

    always_comb begin
        wr_entry = rd_entry;
        wr_en    = 1'b0;
        case (ctl.op)
            OP_TOUCH: begin
                if (is_tgt) begin
                    wr_en         = 1'b1;
                    wr_entry.rank = '0;
                    if (rd_entry.count != COUNT_MAX) begin
                        wr_entry.count = rd_entry.count + COUNT_BITS'(1);
                    end
                    if (ctl.is_put) begin
                        wr_entry.value = ctl.value;
                    end
                end else if (beat_vld && (rd_entry.rank < ctl.ref_rank)) begin
                    wr_en         = 1'b1;
                    wr_entry.rank = rd_entry.rank + RANK_BITS'(1);
                end
            end
            OP_EVICT, OP_FILL: begin
                if (is_tgt) begin
                    wr_en          = 1'b1;
                    wr_entry.key   = ctl.key;
                    wr_entry.value = ctl.value;
                    wr_entry.count = COUNT_INIT;
                    wr_entry.rank  = '0;
                end else if (beat_vld) begin
                    wr_en = 1'b1;
                    if (!((ctl.op == OP_EVICT) && (rd_entry.rank > ctl.ref_rank))) begin
                        wr_entry.rank = rd_entry.rank + RANK_BITS'(1);
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

[rtl/lfu_cache_policy_core.sv]
// ============================================================================
// LFU cache policy core
// Key-value cache with least-frequently-used replacement and an
// least-recently-used tie-break, held in one entry RAM.
// ============================================================================
// A request is taken on the s_axis side and answered by exactly one beat on
// the m_axis side. The entry RAM has one read port, so the controller reads
// every entry once to find the key, the victim and a free slot, and then
// reads and writes back every entry once more to update counts and recency
// ranks. Only a request that changes the table (any get hit, or a put with
// nonzero capacity) takes the second pass; a get miss or a put with capacity
// zero skips it. The two passes never overlap and a new request starts after
// the last write, so no read ever meets a pending write of the same entry.
// The result waits in an output register while the next request is taken in.
module lfu_cache_policy_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // lookup_key [31:0], write_value [63:32]
    input  logic [lcp_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // req_type [0]
    input  logic [lcp_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_value [31:0]
    output logic [lcp_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    // hit [0]
    output logic [lcp_pkg::M_TUSER_BITS-1:0]  m_axis_tuser,
    input  logic                              cfg_wr_en,
    input  logic [lcp_pkg::CAP_BITS-1:0]      cfg_wr_data
);

    import lcp_pkg::*;

    state_t                state_reg;
    state_t                state_next;

    logic                  req_put_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VAL_BITS-1:0]   req_val_reg;

    logic [CAP_BITS-1:0]   cap_reg;
    logic [OCC_BITS-1:0]   occ_reg;
    logic [OCC_BITS-1:0]   occ_next;
    logic                  valid_reg [MAX_ENTRIES];

    logic [IDX_BITS-1:0]   rd_idx_reg;
    logic                  rd_last;
    logic                  beat_reg;
    logic [IDX_BITS-1:0]   beat_idx_reg;

    upd_ctl_t              ctl_reg;
    upd_ctl_t              ctl_next;
    logic                  resp_hit_reg;
    logic [VAL_BITS-1:0]   resp_value_reg;
    logic [VAL_BITS-1:0]   resp_value_next;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [VAL_BITS-1:0]   m_value_reg;

    logic                  accept;
    logic                  rd_en;
    logic                  decide_en;
    logic                  load_out;
    logic                  out_free;
    logic                  scan_beat;
    logic                  upd_beat;
    logic                  beat_vld;

    logic [ENTRY_BITS-1:0] rd_data;
    entry_t                rd_entry;
    entry_t                wr_entry;
    logic                  upd_wr_en;
    scan_res_t             scan_res;

    logic [CMP_BITS-1:0]   cap_ext;
    logic [CMP_BITS-1:0]   cap_eff;
    logic [CMP_BITS-1:0]   occ_ext;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign rd_last  = (rd_idx_reg == IDX_BITS'(MAX_ENTRIES - 1));
    assign beat_vld = valid_reg[beat_idx_reg];
    assign rd_entry = entry_t'(rd_data);

    assign scan_beat = beat_reg && ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_END));
    assign upd_beat  = beat_reg && ((state_reg == ST_UPDATE) || (state_reg == ST_UPD_END));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (ctl_next.op == OP_NONE) ? ST_RESP : ST_UPDATE;
            end
            ST_UPDATE: begin
                if (rd_last) begin
                    state_next = ST_UPD_END;
                end
            end
            ST_UPD_END: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        decide_en     = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN, ST_UPDATE: begin
                rd_en = 1'b1;
            end
            ST_DECIDE: begin
                decide_en = 1'b1;
            end
            ST_RESP: begin
                load_out = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign cap_ext = CMP_BITS'(cap_reg);
    assign cap_eff = (cap_ext > CMP_BITS'(MAX_ENTRIES)) ? CMP_BITS'(MAX_ENTRIES) : cap_ext;
    assign occ_ext = CMP_BITS'(occ_reg);

    always_comb begin
        ctl_next          = ctl_reg;
        ctl_next.op       = OP_NONE;
        ctl_next.is_put   = req_put_reg;
        ctl_next.key      = req_key_reg;
        ctl_next.value    = req_val_reg;
        ctl_next.tgt_idx  = scan_res.match_idx;
        ctl_next.ref_rank = scan_res.match_rank;
        resp_value_next   = PUT_VALUE;
        occ_next          = occ_reg;
        if (req_put_reg == REQ_GET) begin
            resp_value_next = scan_res.found ? scan_res.match_value : MISS_VALUE;
            if (scan_res.found) begin
                ctl_next.op = OP_TOUCH;
            end
        end else if (cap_eff != '0) begin
            if (scan_res.found) begin
                ctl_next.op = OP_TOUCH;
            end else if ((occ_ext >= cap_eff) && scan_res.vic_found) begin
                ctl_next.op       = OP_EVICT;
                ctl_next.tgt_idx  = scan_res.vic_idx;
                ctl_next.ref_rank = scan_res.vic_rank;
            end else if (scan_res.free_found) begin
                ctl_next.op      = OP_FILL;
                ctl_next.tgt_idx = scan_res.free_idx;
                occ_next         = occ_reg + OCC_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            rd_idx_reg  <= '0;
            beat_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            ctl_reg.op  <= OP_NONE;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            beat_reg  <= rd_en;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (rd_en) begin
                rd_idx_reg <= rd_last ? '0 : rd_idx_reg + IDX_BITS'(1);
            end
            if (decide_en) begin
                ctl_reg <= ctl_next;
                occ_reg <= occ_next;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if ((ctl_next.op == OP_FILL) && (ctl_next.tgt_idx == IDX_BITS'(i))) begin
                        valid_reg[i] <= 1'b1;
                    end
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        beat_idx_reg <= rd_idx_reg;
        if (accept) begin
            req_put_reg <= s_axis_tuser[0];
            req_key_reg <= s_axis_tdata[KEY_BITS-1:0];
            req_val_reg <= s_axis_tdata[KEY_BITS+VAL_BITS-1:KEY_BITS];
        end
        if (decide_en) begin
            resp_hit_reg   <= scan_res.found;
            resp_value_reg <= resp_value_next;
        end
        if (load_out) begin
            m_hit_reg   <= resp_hit_reg;
            m_value_reg <= resp_value_reg;
        end
    end

    lcp_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data),
        .wr_en   (upd_beat && upd_wr_en),
        .wr_addr (beat_idx_reg),
        .wr_data (wr_entry)
    );

    lcp_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .beat     (scan_beat),
        .beat_idx (beat_idx_reg),
        .beat_vld (beat_vld),
        .rd_entry (rd_entry),
        .key      (req_key_reg),
        .res      (scan_res)
    );

    lcp_entry_upd u_entry_upd (
        .ctl      (ctl_reg),
        .beat_idx (beat_idx_reg),
        .beat_vld (beat_vld),
        .rd_entry (rd_entry),
        .wr_en    (upd_wr_en),
        .wr_entry (wr_entry)
    );

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = M_TDATA_BITS'(m_value_reg);
    assign m_axis_tuser[0] = m_hit_reg;

endmodule

[rtl/lcp_checker.sv]
// ============================================================================
// LFU cache port checker
// Watches the ports of the core over time and is bound to every instance.
// ============================================================================
`include "lfu_cache_policy_core_assert.svh"

module lcp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lcp_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    input logic [lcp_pkg::M_TUSER_BITS-1:0]  m_axis_tuser
);

    // A stalled result beat must hold its value.
    `LCP_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result beat changed while stalled")

    // The engine works on one request at a time.
    `LCP_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second request taken while busy")

    // No result can be produced in the cycle right after a request is taken.
    `LCP_ASSERT(a_no_early_result, (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid), "result appeared too early")

    // Reset leaves the core ready and the output empty.
    `LCP_ASSERT_ALWAYS(a_reset_state, !aresetn |=> (s_axis_tready && !m_axis_tvalid), "bad state after reset")

endmodule

bind lfu_cache_policy_core lcp_checker u_lcp_checker (.*);
